// ===== sv/hslrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared types and constants of the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

  // Default fraction bits of the Q format
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Hue input, 1/16 degree units
  localparam int unsigned HUE_W = 20;
  // Hue biased nonnegative, then split into high part and 7 low bits (5760 = 128 * 45)
  localparam int unsigned HUE_UW     = 21;
  localparam int unsigned HUE_SPLIT  = 7;
  localparam int unsigned HUE_VW     = HUE_UW - HUE_SPLIT;
  localparam int unsigned HUE_HW     = 13;
  localparam int unsigned HUE_QW     = 9;
  localparam int unsigned HUE_OFFSET = 529920;  // 92 full turns
  localparam int unsigned HUE_RES    = 45;
  localparam int unsigned HUE_DIV_MUL = 364;    // floor(2^14 / 45)
  localparam int unsigned HUE_DIV_SH  = 14;

  localparam int unsigned HUE_TURN       = 5760;
  localparam int unsigned HUE_SIXTH      = 960;
  localparam int unsigned HUE_THIRD      = 1920;
  localparam int unsigned HUE_HALF       = 2880;
  localparam int unsigned HUE_TWO_THIRDS = 3840;

  // Ramp position 0..960
  localparam int unsigned TRW = 10;

  // 960 = 64 * 15: shift by 6, then divide by 15
  localparam int unsigned DIV_SH = 6;
  localparam int unsigned DIV_K  = 15;

  localparam int unsigned NUM_CH = 3;

  // Per-channel hue offsets: red, green, blue
  localparam logic [HUE_HW-1:0] CH_OFFSET [NUM_CH] = '{
    HUE_HW'(HUE_THIRD), HUE_HW'(0), HUE_HW'(HUE_TWO_THIRDS)
  };

  typedef struct packed {
    logic ramp;   // linear segment of the hue rule
    logic use_q;  // flat segment at q (else at p)
  } chan_ctl_t;

endpackage

// ===== sv/hsl_to_rgb_convert.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_convert
// Pipelined HSL to RGB color conversion in Q(FRAC_BITS) fixed point.
// ----------------------------------------------------------------------------
// One pixel is taken in every clock cycle (busy_o stays low) and its result
// appears with done_o high for one cycle. The pipeline has seven register
// stages: saturate with hue bias and l*s, hue wrap with q/p forming,
// segment decode, ramp multiply, sum, reciprocal multiply for the divide
// by 15, and correction with the output register. The receiver cannot
// stall the pipeline, so every beat is taken from the result ports in the
// cycle it is shown.
module hsl_to_rgb_convert import hslrgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [HUE_W-1:0] hue_i,
  input  logic [FRAC_BITS:0]      saturation_i,
  input  logic [FRAC_BITS:0]      lightness_i,
  input  logic                    has_alpha_i,
  input  logic signed [FRAC_BITS+1:0] alpha_in_i,
  output logic                    done_o,
  output logic [FRAC_BITS:0]      red_o,
  output logic [FRAC_BITS:0]      green_o,
  output logic [FRAC_BITS:0]      blue_o,
  output logic [FRAC_BITS:0]      alpha_out_o
);

  localparam int unsigned STAGES = 7;
  localparam int unsigned VW     = FRAC_BITS + 1;
  localparam int unsigned P2W    = 2 * FRAC_BITS + 1;
  localparam int unsigned W2     = P2W + 1;
  localparam int unsigned NUMW   = 2 * FRAC_BITS + 11;
  localparam int unsigned YW     = FRAC_BITS + 4;
  localparam int unsigned MW     = YW - 3;
  localparam logic [VW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VW-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic [MW-1:0] RECIP15 = MW'((64'd1 << YW) / 64'(DIV_K));

  // ---------------- valid chain ----------------
  logic [STAGES-1:0] vld_d, vld_q;

  assign vld_d = {vld_q[STAGES-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[STAGES-1];

  // ---------------- stage 1: saturate, hue bias and quotient estimate, l*s, alpha clamp ----------------
  logic [VW-1:0]       s_sat, l_sat;
  logic [HUE_UW-1:0]   u_d, u_q;
  logic [HUE_VW+HUE_QW-1:0] hq_prod;
  logic [HUE_QW-1:0]   hq_d, hq_q;
  logic [2*VW-1:0]     ls_full;
  logic [P2W-1:0]      ls_d, ls_q;
  logic [VW-1:0]       s1_d, s1_q, l1_d, l1_q;
  logic [VW-1:0]       ao_d, ao1_q;

  always_comb begin
    s_sat   = (saturation_i > ONE) ? ONE : saturation_i;
    l_sat   = (lightness_i > ONE) ? ONE : lightness_i;
    u_d     = HUE_UW'($signed({hue_i[HUE_W-1], hue_i}) +
                      $signed(HUE_UW'(HUE_OFFSET)));
    hq_prod = u_d[HUE_UW-1:HUE_SPLIT] * HUE_QW'(HUE_DIV_MUL);
    hq_d    = hq_prod[HUE_DIV_SH +: HUE_QW];
    ls_full = l_sat * s_sat;
    ls_d    = ls_full[P2W-1:0];
    s1_d    = s_sat;
    l1_d    = l_sat;
    if (!has_alpha_i) begin
      ao_d = ONE;
    end else if (alpha_in_i[FRAC_BITS+1]) begin
      ao_d = '0;
    end else if (alpha_in_i[FRAC_BITS:0] > ONE) begin
      ao_d = ONE;
    end else begin
      ao_d = alpha_in_i[FRAC_BITS:0];
    end
  end

  // ---------------- stage 2: hue mod 5760, q2 and p2 ----------------
  logic [HUE_VW-1:0] rem_full;
  logic [6:0]        rem7;
  logic [HUE_HW-1:0] hm_d, hm_q;
  logic [P2W-1:0]    lone;
  logic [W2-1:0]     q2_full, p2_full;
  logic [VW:0]       lps;
  logic [P2W-1:0]    q2_d, p2_d, q2_2q, p2_2q;
  logic [VW-1:0]     ao2_q;

  always_comb begin
    // quotient estimate may be one low
    rem_full = u_q[HUE_UW-1:HUE_SPLIT] - HUE_VW'(hq_q) * HUE_VW'(HUE_RES);
    rem7     = rem_full[6:0];
    if (rem7 >= 7'(HUE_RES)) begin
      rem7 = rem7 - 7'(HUE_RES);
    end
    hm_d = {rem7[5:0], u_q[HUE_SPLIT-1:0]};

    lone = {l1_q, {FRAC_BITS{1'b0}}};
    lps  = {1'b0, l1_q} + {1'b0, s1_q};
    if (l1_q < HALF) begin
      q2_full = W2'(lone) + W2'(ls_q);
    end else begin
      q2_full = W2'({lps, {FRAC_BITS{1'b0}}}) - W2'(ls_q);
    end
    p2_full = (W2'(lone) << 1) - q2_full;
    q2_d    = q2_full[P2W-1:0];
    p2_d    = p2_full[P2W-1:0];
  end

  // ---------------- stage 3: segment decode per channel ----------------
  logic [HUE_HW:0]   t_sum;
  logic [HUE_HW-1:0] t_ch;
  logic [HUE_HW-1:0] t_down;
  chan_ctl_t         ctl3_d [NUM_CH];
  chan_ctl_t         ctl3_q [NUM_CH];
  logic [TRW-1:0]    tr3_d  [NUM_CH];
  logic [TRW-1:0]    tr3_q  [NUM_CH];
  logic [P2W-1:0]    d3_d, d3_q, p2_3q, q2_3q;
  logic [VW-1:0]     ao3_q;

  always_comb begin
    t_sum  = '0;
    t_ch   = '0;
    t_down = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      t_sum = {1'b0, hm_q} + {1'b0, CH_OFFSET[c]};
      if (t_sum >= (HUE_HW+1)'(HUE_TURN)) begin
        t_sum = t_sum - (HUE_HW+1)'(HUE_TURN);
      end
      t_ch   = t_sum[HUE_HW-1:0];
      t_down = HUE_HW'(HUE_TWO_THIRDS) - t_ch;
      ctl3_d[c].ramp  = (t_ch < HUE_HW'(HUE_SIXTH)) ||
                        ((t_ch >= HUE_HW'(HUE_HALF)) && (t_ch < HUE_HW'(HUE_TWO_THIRDS)));
      ctl3_d[c].use_q = (t_ch >= HUE_HW'(HUE_SIXTH)) && (t_ch < HUE_HW'(HUE_HALF));
      tr3_d[c] = (t_ch < HUE_HW'(HUE_SIXTH)) ? t_ch[TRW-1:0] : t_down[TRW-1:0];
    end
    d3_d = q2_2q - p2_2q;
  end

  // ---------------- stage 4: ramp multiply, flat values ----------------
  logic [NUMW-1:0] dt4_d [NUM_CH];
  logic [NUMW-1:0] dt4_q [NUM_CH];
  logic [P2W:0]    flat_sum;
  logic [VW-1:0]   cv4_d [NUM_CH];
  logic [VW-1:0]   cv4_q [NUM_CH];
  logic            ramp4_q [NUM_CH];
  logic [NUMW-1:0] pk4_d, pk4_q;
  logic [VW-1:0]   ao4_q;

  always_comb begin
    flat_sum = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      dt4_d[c] = NUMW'(d3_q) * NUMW'(tr3_q[c]);
      flat_sum = (ctl3_q[c].use_q ? {1'b0, q2_3q} : {1'b0, p2_3q}) + (P2W+1)'(HALF);
      cv4_d[c] = flat_sum[FRAC_BITS +: VW];
    end
    // p2 * 960 plus half the divisor for round half up
    pk4_d = NUMW'(p2_3q) * NUMW'(HUE_SIXTH) +
            (NUMW'(HUE_SIXTH / 2) << FRAC_BITS);
  end

  // ---------------- stage 5: numerator, shift out 2^(F+6) ----------------
  logic [NUMW-1:0] num5;
  logic [YW-1:0]   y5_d [NUM_CH];
  logic [YW-1:0]   y5_q [NUM_CH];
  logic [VW-1:0]   cv5_q [NUM_CH];
  logic            ramp5_q [NUM_CH];
  logic [VW-1:0]   ao5_q;

  always_comb begin
    num5 = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      num5    = pk4_q + dt4_q[c];
      y5_d[c] = num5[FRAC_BITS+DIV_SH +: YW];
    end
  end

  // ---------------- stage 6: reciprocal multiply by 1/15 ----------------
  logic [YW+MW-1:0] qp6;
  logic [MW-1:0]    qe6_d [NUM_CH];
  logic [MW-1:0]    qe6_q [NUM_CH];
  logic [YW-1:0]    y6_q  [NUM_CH];
  logic [VW-1:0]    cv6_q [NUM_CH];
  logic             ramp6_q [NUM_CH];
  logic [VW-1:0]    ao6_q;

  always_comb begin
    qp6 = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      qp6      = y5_q[c] * RECIP15;
      qe6_d[c] = qp6[YW +: MW];
    end
  end

  // ---------------- stage 7: correction, output select ----------------
  logic [YW-1:0] rem15;
  logic [VW-1:0] qfin;
  logic [VW-1:0] ch_d [NUM_CH];
  logic [VW-1:0] ch_q [NUM_CH];
  logic [VW-1:0] ao7_q;

  always_comb begin
    rem15 = '0;
    qfin  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      // estimate is exact or one low
      rem15 = y6_q[c] - YW'(qe6_q[c]) * YW'(DIV_K);
      qfin  = VW'(qe6_q[c]);
      if (rem15 >= YW'(DIV_K)) begin
        qfin = qfin + VW'(1);
      end
      ch_d[c] = ramp6_q[c] ? qfin : cv6_q[c];
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    hq_q  <= hq_d;
    ls_q  <= ls_d;
    s1_q  <= s1_d;
    l1_q  <= l1_d;
    ao1_q <= ao_d;

    hm_q  <= hm_d;
    q2_2q <= q2_d;
    p2_2q <= p2_d;
    ao2_q <= ao1_q;

    d3_q  <= d3_d;
    p2_3q <= p2_2q;
    q2_3q <= q2_2q;
    ao3_q <= ao2_q;

    pk4_q <= pk4_d;
    ao4_q <= ao3_q;
    ao5_q <= ao4_q;
    ao6_q <= ao5_q;
    ao7_q <= ao6_q;

    for (int c = 0; c < NUM_CH; c++) begin
      ctl3_q[c]  <= ctl3_d[c];
      tr3_q[c]   <= tr3_d[c];
      dt4_q[c]   <= dt4_d[c];
      cv4_q[c]   <= cv4_d[c];
      ramp4_q[c] <= ctl3_q[c].ramp;
      y5_q[c]    <= y5_d[c];
      cv5_q[c]   <= cv4_q[c];
      ramp5_q[c] <= ramp4_q[c];
      qe6_q[c]   <= qe6_d[c];
      y6_q[c]    <= y5_q[c];
      cv6_q[c]   <= cv5_q[c];
      ramp6_q[c] <= ramp5_q[c];
      ch_q[c]    <= ch_d[c];
    end
  end

  assign red_o       = ch_q[0];
  assign green_o     = ch_q[1];
  assign blue_o      = ch_q[2];
  assign alpha_out_o = ao7_q;

endmodule
